@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/flmc_pkg.sv @@
// ----------------------------------------------------------------------------
// flmc_pkg
// Types, codes and lookup functions of the fn-layer strip mode controller.
// ----------------------------------------------------------------------------
package flmc_pkg;

    localparam int STRIP_KEYS = 13;

    typedef enum logic [1:0] {
        MODE_ESC  = 2'd0,
        MODE_FN   = 2'd1,
        MODE_SPCL = 2'd2,
        MODE_OFF  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        FUNC_STRIP_KEY  = 3'd0,
        FUNC_OTHER      = 3'd1,
        FUNC_TICK       = 3'd2,
        FUNC_TIMEOUT    = 3'd3,
        FUNC_FN_MODE    = 3'd4,
        FUNC_START      = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        KEY_RELEASE = 2'd0,
        KEY_PRESS   = 2'd1,
        KEY_REPEAT  = 2'd2
    } key_value_t;

    typedef enum logic [1:0] {
        FNM_FKEYS   = 2'd0,
        FNM_FN_FKEY = 2'd1,
        FNM_INVERSE = 2'd2,
        FNM_SPECIAL = 2'd3
    } fn_mode_t;

    localparam logic CFG_IDX_IDLE_LIMIT = 1'b0;
    localparam logic CFG_IDX_FN_MODE    = 1'b1;

    localparam logic [16:0] IDLE_LIMIT_RST = 17'd300;
    localparam logic [1:0]  FN_MODE_RST    = 2'd1;

    localparam logic [9:0] CODE_ESC = 10'd1;
    localparam logic [9:0] CODE_F1  = 10'd59;
    localparam logic [9:0] CODE_F10 = 10'd68;
    localparam logic [9:0] CODE_F11 = 10'd87;
    localparam logic [9:0] CODE_F12 = 10'd88;
    localparam logic [9:0] CODE_FN  = 10'd464;

    localparam logic [3:0]  SLOT_NONE = 4'hF;
    localparam logic [15:0] IDLE_MAX  = 16'hFFFF;

    typedef struct packed {
        logic signed [16:0] idle_limit;
        logic [1:0]         fn_mode;
    } cfg_t;

    typedef struct packed {
        logic [2:0] func;
        logic       is_key_event;
        logic [9:0] key_code;
        logic [1:0] key_value;
    } item_t;

    typedef struct packed {
        logic       translated_valid;
        logic [9:0] translated_code;
        logic       mode_cmd_valid;
        mode_t      mode_cmd;
    } res_t;

    // Esc is slot 0, F1-F12 are slots 1-12
    function automatic logic [3:0] key_slot(input logic [9:0] code);
        logic [9:0] diff;
        diff = code - CODE_F1 + 10'd1;
        if (code == CODE_ESC) begin
            return 4'd0;
        end
        if (code >= CODE_F1 && code <= CODE_F10) begin
            return diff[3:0];
        end
        if (code == CODE_F11) begin
            return 4'd11;
        end
        if (code == CODE_F12) begin
            return 4'd12;
        end
        return SLOT_NONE;
    endfunction

    function automatic logic [9:0] special_code(input logic [3:0] slot);
        logic [9:0] code;
        unique case (slot)
            4'd1:    code = 10'd224;
            4'd2:    code = 10'd225;
            4'd3:    code = 10'd120;
            4'd4:    code = 10'd204;
            4'd5:    code = 10'd229;
            4'd6:    code = 10'd230;
            4'd7:    code = 10'd165;
            4'd8:    code = 10'd164;
            4'd9:    code = 10'd163;
            4'd10:   code = 10'd113;
            4'd11:   code = 10'd114;
            4'd12:   code = 10'd115;
            default: code = 10'd0;
        endcase
        return code;
    endfunction

    function automatic mode_t wanted_mode(input logic [1:0] fn_mode, input logic fn_held);
        mode_t m;
        unique case (fn_mode)
            FNM_FKEYS:   m = MODE_FN;
            FNM_SPECIAL: m = MODE_SPCL;
            FNM_INVERSE: m = fn_held ? MODE_SPCL : MODE_FN;
            default:     m = fn_held ? MODE_FN : MODE_SPCL;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/flmc_if.sv @@
// ----------------------------------------------------------------------------
// flmc_if
// Valid/ready channels for input events and controller results.
// ----------------------------------------------------------------------------
interface flmc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic       is_key_event;
    logic [9:0] key_code;
    logic [1:0] key_value;

    modport source (output valid, func, is_key_event, key_code, key_value, input ready);
    modport sink   (input valid, func, is_key_event, key_code, key_value, output ready);
endinterface

interface flmc_out_if;
    logic       valid;
    logic       ready;
    logic       translated_valid;
    logic [9:0] translated_code;
    logic       mode_cmd_valid;
    logic [1:0] mode_cmd;

    modport source (output valid, translated_valid, translated_code, mode_cmd_valid,
                    mode_cmd, input ready);
    modport sink   (input valid, translated_valid, translated_code, mode_cmd_valid,
                    mode_cmd, output ready);
endinterface

@@ rtl/flmc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// flmc_cfg_regs
// APB register file holding idle_limit and fn_mode.
// ----------------------------------------------------------------------------
module flmc_cfg_regs import flmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic signed [16:0] idle_limit_reg;
    logic [1:0]         fn_mode_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RST;
            fn_mode_reg    <= FN_MODE_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                CFG_IDX_IDLE_LIMIT: idle_limit_reg <= pwdata[16:0];
                default:            fn_mode_reg    <= pwdata[1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            CFG_IDX_IDLE_LIMIT: prdata = {{15{idle_limit_reg[16]}}, idle_limit_reg};
            default:            prdata = {30'd0, fn_mode_reg};
        endcase
    end

    assign cfg.idle_limit = idle_limit_reg;
    assign cfg.fn_mode    = fn_mode_reg;

endmodule

@@ rtl/flmc_engine.sv @@
// ----------------------------------------------------------------------------
// flmc_engine
// Controller state, single-pass next-state logic and the result register.
// ----------------------------------------------------------------------------
module flmc_engine import flmc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  item_t         item,
    input  logic          item_valid,
    output logic          item_take,
    output mode_t         mode,
    flmc_out_if.source    out_ch
);

    logic [STRIP_KEYS-1:0] held_reg, held_next;
    logic                  fn_held_reg, fn_held_next;
    mode_t                 mode_reg, mode_next;
    logic [15:0]           idle_reg, idle_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  res_reg, res_next;

    logic [3:0]  slot;
    logic [5:0]  slot_ext;
    logic        slot_ok;
    logic        is_press;
    logic        any_held;
    logic        to_zero, to_neg, to_pos;
    logic [15:0] to_val;
    logic [15:0] idle_inc;
    mode_t       want;
    logic        do_switch;

    assign item_take = item_valid && (!out_valid_reg || out_ch.ready);

    assign slot     = key_slot(item.key_code);
    assign slot_ext = {2'b00, slot};
    assign slot_ok  = slot != SLOT_NONE;
    assign is_press = item.key_value != KEY_RELEASE;
    assign to_zero  = cfg.idle_limit == 17'sd0;
    assign to_neg   = cfg.idle_limit[16];
    assign to_pos   = !to_neg && !to_zero;
    assign to_val   = cfg.idle_limit[15:0];
    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

    // key and fn bookkeeping comes first; mode decisions see the updated state
    always_comb
    begin
        held_next    = held_reg;
        fn_held_next = fn_held_reg;
        unique case (item.func)
            FUNC_STRIP_KEY:
            begin
                if (slot_ok && item.is_key_event && item.key_value != KEY_REPEAT &&
                    slot_ext < 6'(STRIP_KEYS))
                begin
                    for (int i = 0; i < STRIP_KEYS; i++)
                    begin
                        if (slot_ext == 6'(i))
                        begin
                            held_next[i] = is_press;
                        end
                    end
                end
            end
            FUNC_OTHER:
            begin
                if (item.is_key_event && item.key_code == CODE_FN &&
                    item.key_value != KEY_REPEAT)
                begin
                    fn_held_next = is_press;
                end
            end
            FUNC_START:
            begin
                held_next    = '0;
                fn_held_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign any_held  = |held_next;
    assign want      = wanted_mode(cfg.fn_mode, fn_held_next);
    assign do_switch = !to_zero && (mode_reg != want) && !any_held;

    always_comb
    begin
        mode_next = mode_reg;
        idle_next = idle_reg;
        res_next  = '0;
        unique case (item.func)
            FUNC_STRIP_KEY:
            begin
                if (slot_ok)
                begin
                    idle_next = '0;
                    if (do_switch)
                    begin
                        mode_next          = want;
                        res_next.mode_cmd_valid = 1'b1;
                        res_next.mode_cmd  = want;
                    end
                    if (item.is_key_event && slot != 4'd0 && mode_next == MODE_SPCL)
                    begin
                        res_next.translated_valid = 1'b1;
                        res_next.translated_code  = special_code(slot);
                    end
                end
            end
            FUNC_OTHER, FUNC_FN_MODE:
            begin
                if (item.func == FUNC_OTHER)
                begin
                    idle_next = '0;
                end
                if (do_switch)
                begin
                    mode_next               = want;
                    idle_next               = '0;
                    res_next.mode_cmd_valid = 1'b1;
                    res_next.mode_cmd       = want;
                end
            end
            FUNC_TICK:
            begin
                idle_next = idle_inc;
                if (to_pos && idle_inc >= to_val && !any_held && mode_reg != MODE_OFF)
                begin
                    mode_next               = MODE_OFF;
                    res_next.mode_cmd_valid = 1'b1;
                    res_next.mode_cmd       = MODE_OFF;
                end
            end
            FUNC_TIMEOUT:
            begin
                priority if (to_neg)
                begin
                    if (mode_reg == MODE_OFF)
                    begin
                        mode_next               = want;
                        idle_next               = '0;
                        res_next.mode_cmd_valid = 1'b1;
                        res_next.mode_cmd       = want;
                    end
                end
                else if (to_zero)
                begin
                    mode_next               = MODE_OFF;
                    idle_next               = '0;
                    res_next.mode_cmd_valid = 1'b1;
                    res_next.mode_cmd       = MODE_OFF;
                end
                else if (idle_reg >= to_val && !any_held)
                begin
                    mode_next               = MODE_OFF;
                    res_next.mode_cmd_valid = 1'b1;
                    res_next.mode_cmd       = MODE_OFF;
                end
                else
                begin
                end
            end
            FUNC_START:
            begin
                mode_next               = to_zero ? MODE_OFF : want;
                idle_next               = '0;
                res_next.mode_cmd_valid = 1'b1;
                res_next.mode_cmd       = to_zero ? MODE_OFF : want;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (item_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            fn_held_reg   <= 1'b0;
            mode_reg      <= MODE_OFF;
            idle_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (item_take)
            begin
                held_reg    <= held_next;
                fn_held_reg <= fn_held_next;
                mode_reg    <= mode_next;
                idle_reg    <= idle_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            res_reg <= res_next;
        end
    end

    assign mode                    = mode_reg;
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.translated_valid = res_reg.translated_valid;
    assign out_ch.translated_code  = res_reg.translated_code;
    assign out_ch.mode_cmd_valid   = res_reg.mode_cmd_valid;
    assign out_ch.mode_cmd         = res_reg.mode_cmd;

endmodule

@@ rtl/fn_layer_mode_controller_core.sv @@
// An accepted transaction waits in the input register until the engine
// writes its result to the result register. Throughput: one transaction per
// cycle; both registers advance every cycle the output side is not stalled.
// Reset (rst_n, async, active low): no keys held, fn released, strip off,
// idle counter zero, idle limit 300, fn_mode 1, both channels empty.
// ----------------------------------------------------------------------------
// fn_layer_mode_controller_core
// Top level: APB registers, input register and the controller engine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fn_layer_mode_controller_core import flmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    flmc_in_if.sink     in_ch,
    flmc_out_if.source  out_ch
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_valid_reg, in_valid_next;
    logic  item_take;
    mode_t mode;

    flmc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_ch.ready = !in_valid_reg || item_take;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ch.valid && in_ch.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (item_take)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg.func         <= in_ch.func;
            item_reg.is_key_event <= in_ch.is_key_event;
            item_reg.key_code     <= in_ch.key_code;
            item_reg.key_value    <= in_ch.key_value;
        end
    end

    flmc_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item_reg),
        .item_valid (in_valid_reg),
        .item_take  (item_take),
        .mode       (mode),
        .out_ch     (out_ch)
    );

    // a buffered transaction must move on whenever the result register is free
    `ASSERT_NEVER(a_no_idle_stall, clk, rst_n, in_valid_reg && !out_ch.valid && !item_take, "engine stalled with empty result register")
    `ASSERT_CLK(a_take_fills_out, clk, rst_n, item_take |=> out_ch.valid, "processed transaction lost")
    `ASSERT_CLK(a_xlate_in_spcl, clk, rst_n, item_take |=> (!out_ch.translated_valid || mode == MODE_SPCL), "translation outside special mode")

endmodule

@@ tb/flmc_checker.sv @@
// ----------------------------------------------------------------------------
// flmc_checker
// Watches the APB port and both channels of the fn-layer strip mode
// controller. It keeps its own copy of the registers and the controller state
// and predicts one result per accepted input transaction. Each accepted result
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module flmc_checker import flmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    flmc_in_if          in_mon,
    flmc_out_if         out_mon,
    output int          errors,
    output int          pending
);

    localparam logic [2:0] ADDR_IDLE_LIMIT = {CFG_IDX_IDLE_LIMIT, 2'b00};
    localparam logic [2:0] ADDR_FN_MODE    = {CFG_IDX_FN_MODE, 2'b00};

    logic signed [16:0] timeout_cfg;
    logic [1:0]         fn_mode_cfg;
    logic [12:0]        held_keys;
    logic               fn_down;
    mode_t              strip_mode;
    logic [15:0]        idle_count;

    res_t  result_q[$];
    res_t  oldest;
    item_t seen;

    function automatic int strip_slot(input logic [9:0] code);
        if (code == CODE_ESC) return 0;
        if (code >= CODE_F1 && code <= CODE_F10) return int'(code - CODE_F1) + 1;
        if (code == CODE_F11) return 11;
        if (code == CODE_F12) return 12;
        return -1;
    endfunction

    function automatic logic [9:0] media_code(input int slot);
        logic [9:0] code;
        case (slot)
            1:       code = 10'd224;
            2:       code = 10'd225;
            3:       code = 10'd120;
            4:       code = 10'd204;
            5:       code = 10'd229;
            6:       code = 10'd230;
            7:       code = 10'd165;
            8:       code = 10'd164;
            9:       code = 10'd163;
            10:      code = 10'd113;
            11:      code = 10'd114;
            default: code = 10'd115;
        endcase
        return code;
    endfunction

    function automatic mode_t desired_mode();
        mode_t m;
        case (fn_mode_cfg)
            FNM_FKEYS:   m = MODE_FN;
            FNM_SPECIAL: m = MODE_SPCL;
            FNM_INVERSE: m = fn_down ? MODE_SPCL : MODE_FN;
            default:     m = fn_down ? MODE_FN : MODE_SPCL;
        endcase
        return m;
    endfunction

    function automatic res_t issue_mode(input res_t r, input mode_t m);
        res_t o;
        o = r;
        strip_mode = m;
        idle_count = '0;
        o.mode_cmd_valid = 1'b1;
        o.mode_cmd = m;
        return o;
    endfunction

    function automatic res_t maybe_switch(input res_t r);
        mode_t want;
        want = desired_mode();
        if (timeout_cfg != 17'sd0 && strip_mode != want && held_keys == '0) begin
            return issue_mode(r, want);
        end
        return r;
    endfunction

    function automatic res_t predict_strip(input item_t it);
        res_t r;
        int   slot;
        r = '0;
        slot = strip_slot(it.key_code);
        case (it.func)
            FUNC_STRIP_KEY: begin
                if (slot >= 0) begin
                    if (it.is_key_event && it.key_value != KEY_REPEAT) begin
                        held_keys[slot] = (it.key_value != KEY_RELEASE);
                    end
                    idle_count = '0;
                    r = maybe_switch(r);
                    if (it.is_key_event && slot >= 1 && strip_mode == MODE_SPCL) begin
                        r.translated_valid = 1'b1;
                        r.translated_code = media_code(slot);
                    end
                end
            end
            FUNC_OTHER: begin
                if (it.is_key_event && it.key_code == CODE_FN && it.key_value != KEY_REPEAT) begin
                    fn_down = (it.key_value != KEY_RELEASE);
                end
                idle_count = '0;
                r = maybe_switch(r);
            end
            FUNC_TICK: begin
                if (idle_count != IDLE_MAX) idle_count = idle_count + 16'd1;
                if (timeout_cfg > 17'sd0 && int'(idle_count) >= int'(timeout_cfg)
                    && held_keys == '0 && strip_mode != MODE_OFF) begin
                    strip_mode = MODE_OFF;
                    r.mode_cmd_valid = 1'b1;
                    r.mode_cmd = MODE_OFF;
                end
            end
            FUNC_TIMEOUT: begin
                if (timeout_cfg < 17'sd0) begin
                    if (strip_mode == MODE_OFF) r = issue_mode(r, desired_mode());
                end else if (timeout_cfg == 17'sd0) begin
                    r = issue_mode(r, MODE_OFF);
                end else if (int'(idle_count) >= int'(timeout_cfg) && held_keys == '0) begin
                    strip_mode = MODE_OFF;
                    r.mode_cmd_valid = 1'b1;
                    r.mode_cmd = MODE_OFF;
                end
            end
            FUNC_FN_MODE: begin
                r = maybe_switch(r);
            end
            FUNC_START: begin
                held_keys = '0;
                fn_down = 1'b0;
                r = issue_mode(r, (timeout_cfg == 17'sd0) ? MODE_OFF : desired_mode());
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [9:0] want,
                                        input logic [9:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            timeout_cfg = IDLE_LIMIT_RST;
            fn_mode_cfg = FN_MODE_RST;
            held_keys   = '0;
            fn_down     = 1'b0;
            strip_mode  = MODE_OFF;
            idle_count  = '0;
            result_q.delete();
            errors      = 0;
            pending     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_IDLE_LIMIT) timeout_cfg = pwdata[16:0];
                else if (paddr == ADDR_FN_MODE) fn_mode_cfg = pwdata[1:0];
            end
            if (out_mon.valid && out_mon.ready) begin
                if (result_q.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    errors++;
                end else begin
                    oldest = result_q.pop_front();
                    check_field("translated_valid", 10'(oldest.translated_valid),
                                10'(out_mon.translated_valid));
                    check_field("translated_code", oldest.translated_code,
                                out_mon.translated_code);
                    check_field("mode_cmd_valid", 10'(oldest.mode_cmd_valid),
                                10'(out_mon.mode_cmd_valid));
                    check_field("mode_cmd", 10'(oldest.mode_cmd), 10'(out_mon.mode_cmd));
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                seen.func         = in_mon.func;
                seen.is_key_event = in_mon.is_key_event;
                seen.key_code     = in_mon.key_code;
                seen.key_value    = in_mon.key_value;
                result_q.push_back(predict_strip(seen));
            end
            pending = result_q.size();
        end
    end

endmodule

@@ tb/fn_layer_mode_controller_core_tb.sv @@
// ----------------------------------------------------------------------------
// fn_layer_mode_controller_core_tb
// Drives the strip mode controller with a directed set of key, tick and
// control events, then with random event streams under several register
// settings and stall patterns, and a short tick run before the widest
// timeouts. A separate checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module fn_layer_mode_controller_core_tb;
    import flmc_pkg::*;

    localparam logic [2:0] FUNC_RSVD6   = 3'd6;
    localparam logic [2:0] FUNC_RSVD7   = 3'd7;
    localparam int         SETTLE       = 4;
    localparam int         PHASE_ITEMS  = 175;
    localparam int         HOLD_AT      = 150;
    localparam int         HOLD_CYCLES  = 80;
    localparam int         SAT_TICKS    = 20;
    localparam int         CYCLE_LIMIT  = 400000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int src_idle_pct;
    int snk_idle_pct;
    int cycle_count;
    int results_seen;
    int hold_left;
    bit hold_done;

    flmc_in_if  in_ch();
    flmc_out_if out_ch();

    fn_layer_mode_controller_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    flmc_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .in_mon  (in_ch),
        .out_mon (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count > CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready) results_seen++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (results_seen == HOLD_AT && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    function automatic item_t mk(input logic [2:0] f, input logic k, input logic [9:0] c,
                                 input logic [1:0] v);
        item_t it;
        it.func         = f;
        it.is_key_event = k;
        it.key_code     = c;
        it.key_value    = v;
        return it;
    endfunction

    function automatic logic [9:0] strip_code(input int slot);
        if (slot == 0) return CODE_ESC;
        if (slot <= 10) return CODE_F1 + 10'(slot - 1);
        if (slot == 11) return CODE_F11;
        return CODE_F12;
    endfunction

    function automatic item_t random_item();
        int         pick;
        int         roll;
        logic [1:0] val;
        pick = $urandom_range(0, 99);
        roll = $urandom_range(0, 99);
        val = (roll < 50) ? KEY_RELEASE : (roll < 85) ? KEY_PRESS : KEY_REPEAT;
        if (pick < 35) return mk(FUNC_STRIP_KEY, $urandom_range(0, 9) != 0,
                                 strip_code($urandom_range(0, 12)), val);
        if (pick < 45) return mk(FUNC_OTHER, 1'b1, CODE_FN, val);
        if (pick < 55) return mk(FUNC_OTHER, 1'($urandom_range(0, 1)),
                                 10'($urandom_range(0, 767)), 2'($urandom_range(0, 2)));
        if (pick < 80) return mk(FUNC_TICK, 1'($urandom_range(0, 1)),
                                 10'($urandom_range(0, 767)), 2'($urandom_range(0, 2)));
        if (pick < 86) return mk(FUNC_TIMEOUT, 1'b0, '0, KEY_RELEASE);
        if (pick < 92) return mk(FUNC_FN_MODE, 1'b0, '0, KEY_RELEASE);
        if (pick < 96) return mk(FUNC_START, 1'b0, '0, KEY_RELEASE);
        if (pick < 98) return mk(FUNC_STRIP_KEY, 1'($urandom_range(0, 1)),
                                 10'($urandom_range(0, 767)), 2'($urandom_range(0, 2)));
        return mk(pick[0] ? FUNC_RSVD7 : FUNC_RSVD6, 1'($urandom_range(0, 1)),
                  10'($urandom_range(0, 767)), 2'($urandom_range(0, 2)));
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= it.func;
        in_ch.is_key_event <= it.is_key_event;
        in_ch.key_code     <= it.key_code;
        in_ch.key_value    <= it.key_value;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input logic signed [16:0] tmo, input logic [1:0] fnm);
        logic [31:0] w;
        drain();
        w = $urandom;
        w[16:0] = tmo;
        apb_write({CFG_IDX_IDLE_LIMIT, 2'b00}, w);
        w = $urandom;
        w[1:0] = fnm;
        apb_write({CFG_IDX_FN_MODE, 2'b00}, w);
        send_item(mk(FUNC_TIMEOUT, 1'b0, '0, KEY_RELEASE));
        send_item(mk(FUNC_FN_MODE, 1'b0, '0, KEY_RELEASE));
    endtask

    task automatic run_directed();
        send_item(mk(FUNC_START, 1'b0, '0, KEY_RELEASE));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(1), KEY_PRESS));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(12), KEY_REPEAT));
        send_item(mk(FUNC_OTHER, 1'b1, CODE_FN, KEY_PRESS));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(1), KEY_RELEASE));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(0), KEY_PRESS));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(0), KEY_RELEASE));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(11), KEY_PRESS));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(11), KEY_RELEASE));
        send_item(mk(FUNC_OTHER, 1'b1, CODE_FN, KEY_REPEAT));
        send_item(mk(FUNC_OTHER, 1'b1, CODE_FN, KEY_RELEASE));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(10), KEY_PRESS));
        send_item(mk(FUNC_STRIP_KEY, 1'b0, strip_code(5), KEY_RELEASE));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(10), KEY_RELEASE));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, 10'd767, KEY_PRESS));
        send_item(mk(FUNC_OTHER, 1'b0, 10'd464, KEY_PRESS));
        send_item(mk(FUNC_RSVD6, 1'b1, 10'd767, KEY_REPEAT));
        send_item(mk(FUNC_RSVD7, 1'b0, 10'd256, KEY_PRESS));
        send_item(mk(FUNC_TICK, 1'b0, '0, KEY_RELEASE));
        send_item(mk(FUNC_TICK, 1'b1, 10'd512, KEY_REPEAT));
        send_item(mk(FUNC_TIMEOUT, 1'b0, '0, KEY_RELEASE));
        send_item(mk(FUNC_FN_MODE, 1'b0, '0, KEY_RELEASE));
        configure(17'sd0, FNM_INVERSE);
        send_item(mk(FUNC_TIMEOUT, 1'b0, '0, KEY_RELEASE));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(3), KEY_PRESS));
        send_item(mk(FUNC_START, 1'b0, '0, KEY_RELEASE));
        configure(-17'sd1, FNM_SPECIAL);
        configure(-17'sd1, FNM_FKEYS);
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.func         <= '0;
        in_ch.is_key_event <= 1'b0;
        in_ch.key_code     <= '0;
        in_ch.key_value    <= '0;
        src_idle_pct       = 35;
        snk_idle_pct       = 56;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       configure(17'sd3, FNM_FN_FKEY);
                1:       configure(17'sd0, FNM_INVERSE);
                2:       configure(17'sd1, FNM_INVERSE);
                3:       configure(-17'sd1, FNM_FKEYS);
                4:       configure(17'sd5, FNM_SPECIAL);
                default: configure(17'sd2, FNM_FN_FKEY);
            endcase
            if (ph == 2)
            begin
                src_idle_pct = 56;
                snk_idle_pct = 35;
            end
            else if (ph == 4)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            send_item(mk(FUNC_START, 1'b0, '0, KEY_RELEASE));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 2 && n == PHASE_ITEMS / 2) drain();
                send_item(random_item());
            end
        end

        // tick run, then the widest and most negative timeouts
        configure(-17'sd1, FNM_FN_FKEY);
        for (int n = 0; n < SAT_TICKS; n++)
        begin
            send_item(mk(FUNC_TICK, 1'b0, '0, KEY_RELEASE));
        end
        configure(17'sd65535, FNM_FN_FKEY);
        send_item(mk(FUNC_TICK, 1'b0, '0, KEY_RELEASE));
        configure(-17'sd65536, FNM_INVERSE);
        send_item(mk(FUNC_OTHER, 1'b1, CODE_FN, KEY_PRESS));
        send_item(mk(FUNC_STRIP_KEY, 1'b1, strip_code(7), KEY_REPEAT));

        drain();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
